// ===== hw/rtl/kd_tree_point_partition_assert.svh =====
// assertion helpers used by kd_tree_point_partition.sv
`ifndef KD_TREE_POINT_PARTITION_ASSERT_SVH
`define KD_TREE_POINT_PARTITION_ASSERT_SVH

// condition must hold at every edge out of reset
`define KDP_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define KDP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KDP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kdp_pkg.sv =====
package kdp_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TREE_DEPTH = 1'd1;

   // split mode codes
   localparam logic MODE_MEAN   = 1'b0;
   localparam logic MODE_MIDDLE = 1'b1;

   localparam logic [CSR_DATA_W-1:0] DEPTH_RESET = 3'd6;
   localparam int LEAF_W = 5;

   // tree levels including the root, bounded by the depth register and leaf id widths
   localparam int MAX_LEVELS = 6;

   typedef struct packed {
      logic busy;
      logic done;
   } kdp_div_stat_type;

endpackage

// ===== hw/rtl/kdp_div.sv =====
module kdp_div #(
   parameter int SUM_W = 23,
   parameter int CNT_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic        [CNT_W-1:0]  divisor,
   output kdp_pkg::kdp_div_stat_type stat,
   output logic signed [SUM_W-1:0]  quotient
);
   import kdp_pkg::*;

   localparam int NW = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] q_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [CNT_W-1:0] d_ff;
   logic             neg_ff;
   logic [NW-1:0]    n_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;
   logic             ge;

   // one quotient bit per cycle, restoring, on the magnitude
   assign trial = {rem_ff, q_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, d_ff};
   assign diff  = trial - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff    <= NW'(SUM_W);
            q_ff    <= dividend[SUM_W-1] ? (-dividend) : dividend;
            rem_ff  <= '0;
            d_ff    <= divisor;
            neg_ff  <= dividend[SUM_W-1];
         end else if (busy_ff) begin
            q_ff   <= {q_ff[SUM_W-2:0], ge};
            rem_ff <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            n_ff   <= n_ff - NW'(1);
            if (n_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // floor toward minus infinity for negative sums
   always_comb begin
      if (!neg_ff)
         quotient = signed'(q_ff);
      else if (rem_ff != '0)
         quotient = signed'(~q_ff);
      else
         quotient = signed'(-q_ff);
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/kd_tree_point_partition.sv =====
// load: one point per cycle while idle; the final point of a non-empty set starts the build
// build: per inner node, mean mode runs a sum sweep and the bit-serial divider (SUM_W = 23)
//   before the assign sweep, middle mode only the assign sweep, all on the one read port
// readout: each point is read, then checked, in a sweep per leaf over all N points; output
//   stalls hold it; not ready from the final point until the last point is registered
// reset: split_mode mean, tree_depth 6, set emptied; point memories are not cleared
`include "kd_tree_point_partition_assert.svh"
module kd_tree_point_partition #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_BITS-1:0]           req_pos_x,
   input  logic signed [COORD_BITS-1:0]           req_pos_y,
   input  logic                                   req_dropped,
   input  logic                                   req_final_point,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [COORD_BITS-1:0]           rsp_out_x,
   output logic signed [COORD_BITS-1:0]           rsp_out_y,
   output logic [kdp_pkg::LEAF_W-1:0]             rsp_leaf_id,
   output logic                                   rsp_end_of_set,
   input  logic                                   csr_we,
   input  logic [kdp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [kdp_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import kdp_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW  = $clog2(MAX_POINTS + 1);
   localparam int SW  = CB + CW;
   localparam int PW  = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
   localparam int LVW = $clog2(MAX_LEVELS + 1);
   localparam int SKW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int RPW = 2 * CB + LEAF_W + 1;
   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic [PW-1:0] ALL1 = {PW{1'b1}};
   localparam logic [PW-1:0] MSB1 = PW'(1) << (PW - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_NODE, ST_SUM, ST_DIV, ST_ASGN, ST_NEXT, ST_EMIT_RD, ST_EMIT_CHK
   } state_type;

   state_type state_ff;

   // configuration
   logic            split_mode_ff;
   logic [2:0]      tree_depth_ff;

   // point set
   logic [CW-1:0]          count_ff;
   logic signed [CB-1:0]   box_lx_ff, box_ly_ff, box_hx_ff, box_hy_ff;

   // point memories
   logic signed [CB-1:0] mem_x [MAX_POINTS];
   logic signed [CB-1:0] mem_y [MAX_POINTS];
   logic [PW-1:0]        mem_leaf [MAX_POINTS];
   logic signed [CB-1:0] rd_x_ff, rd_y_ff;
   logic [PW-1:0]        rd_leaf_ff;
   logic [AW-1:0]        rd_addr;

   // traversal
   logic [LVW-1:0]       depth_ff;
   logic [LVW-1:0]       lvl_ff;
   logic [PW-1:0]        path_ff;
   logic signed [CB-1:0] cur_lx_ff, cur_ly_ff, cur_hx_ff, cur_hy_ff;
   logic signed [CB-1:0] stk_lx [MAX_LEVELS];
   logic signed [CB-1:0] stk_ly [MAX_LEVELS];
   logic signed [CB-1:0] stk_hx [MAX_LEVELS];
   logic signed [CB-1:0] stk_hy [MAX_LEVELS];
   logic                 on_x_ff;
   logic signed [CB-1:0] split_ff;

   // sweep
   logic [CW-1:0]        idx_ff;
   logic                 pv_ff;
   logic [AW-1:0]        pidx_ff;
   logic signed [SW-1:0] acc_ff;
   logic [CW-1:0]        cnt_ff;

   // readout
   logic [PW-1:0]        lf_ff;
   logic [CW-1:0]        em_cnt_ff;
   logic                 rsp_valid_ff;
   logic signed [CB-1:0] out_x_ff, out_y_ff;
   logic [LEAF_W-1:0]    out_leaf_ff;
   logic                 out_end_ff;

   // divider
   logic                 div_start;
   kdp_div_stat_type     div_stat;
   logic signed [SW-1:0] div_q;

   // combinational helpers
   logic                 in_xfer, store_pt, out_xfer;
   logic [CW-1:0]        count_new;
   logic signed [CB-1:0] nlx, nly, nhx, nhy;
   logic [LVW-1:0]       depth_clamp;
   logic signed [CB:0]   dx, dy, mid;
   logic                 on_x_now;
   logic [PW-1:0]        top_mask, bitpos, leaf_mask, lf_step;
   logic                 node_match, emit_match;
   logic signed [CB-1:0] sel_coord;
   logic                 issue, sweep_end;
   logic [PW-1:0]        new_leaf;
   logic                 leaf_we;
   logic [AW-1:0]        leaf_wa;
   logic [PW-1:0]        leaf_wd;
   logic                 found;
   logic [LVW-1:0]       jsel;
   logic [LVW-1:0]       sh_d, sh_lo;
   logic [PW+LEAF_W-1:0] leaf_wide;
   logic signed [CB-1:0] lft_hx, lft_hy, rgt_lx, rgt_ly;
   logic                 out_free;
   logic                 emit_now;
   logic                 emitting;
   logic                 rsp_stall;
   logic [RPW-1:0]       rsp_payload;

   assign in_xfer   = req_valid && req_ready;
   assign out_xfer  = rsp_valid_ff && rsp_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign store_pt  = in_xfer && !req_dropped && (count_ff < CW'(MAX_POINTS));
   assign count_new = store_pt ? count_ff + CW'(1) : count_ff;
   assign nlx = (store_pt && req_pos_x < box_lx_ff) ? req_pos_x : box_lx_ff;
   assign nly = (store_pt && req_pos_y < box_ly_ff) ? req_pos_y : box_ly_ff;
   assign nhx = (store_pt && req_pos_x > box_hx_ff) ? req_pos_x : box_hx_ff;
   assign nhy = (store_pt && req_pos_y > box_hy_ff) ? req_pos_y : box_hy_ff;

   always_comb begin
      if (tree_depth_ff == 3'd0)
         depth_clamp = LVW'(1);
      else if (int'(tree_depth_ff) > MAX_LEVELS)
         depth_clamp = LVW'(MAX_LEVELS);
      else
         depth_clamp = LVW'(tree_depth_ff);
   end

   // split axis and middle split of the current node box
   assign dx       = (CB+1)'(cur_hx_ff) - (CB+1)'(cur_lx_ff);
   assign dy       = (CB+1)'(cur_hy_ff) - (CB+1)'(cur_ly_ff);
   assign on_x_now = dx > dy;
   assign mid      = on_x_now ? (((CB+1)'(cur_lx_ff) + (CB+1)'(cur_hx_ff)) >>> 1)
                              : (((CB+1)'(cur_ly_ff) + (CB+1)'(cur_hy_ff)) >>> 1);

   assign top_mask   = ~(ALL1 >> lvl_ff);
   assign bitpos     = MSB1 >> lvl_ff;
   assign node_match = (rd_leaf_ff & top_mask) == (path_ff & top_mask);
   assign sel_coord  = on_x_ff ? rd_x_ff : rd_y_ff;
   assign new_leaf   = rd_leaf_ff | ((sel_coord >= split_ff) ? bitpos : '0);
   assign issue      = idx_ff < count_ff;
   assign sweep_end  = !issue && !pv_ff;
   assign rd_addr    = idx_ff[AW-1:0];

   assign sh_d       = depth_ff - LVW'(1);
   assign sh_lo      = LVW'(PW) - sh_d;
   assign leaf_mask  = ~(ALL1 >> sh_d);
   assign lf_step    = PW'((PW+1)'(1) << sh_lo);
   assign emit_match = (rd_leaf_ff & leaf_mask) == lf_ff;
   assign leaf_wide  = {{LEAF_W{1'b0}}, lf_ff} >> sh_lo;
   assign emit_now   = (state_ff == ST_EMIT_CHK) && emit_match && out_free;

   assign lft_hx = on_x_ff ? split_ff : cur_hx_ff;
   assign lft_hy = on_x_ff ? cur_hy_ff : split_ff;
   assign rgt_lx = on_x_ff ? split_ff : cur_lx_ff;
   assign rgt_ly = on_x_ff ? cur_ly_ff : split_ff;

   // deepest ancestor level still on its left branch
   always_comb begin
      found = 1'b0;
      jsel  = '0;
      for (int j = 1; j < MAX_LEVELS; j++) begin
         if (LVW'(j) <= lvl_ff && !path_ff[PW-j]) begin
            found = 1'b1;
            jsel  = LVW'(j);
         end
      end
   end

   assign div_start = (state_ff == ST_SUM) && sweep_end && (cnt_ff != '0);

   always_comb begin
      leaf_we = 1'b0;
      leaf_wa = pidx_ff;
      leaf_wd = new_leaf;
      if (store_pt) begin
         leaf_we = 1'b1;
         leaf_wa = count_ff[AW-1:0];
         leaf_wd = '0;
      end else if (state_ff == ST_ASGN && pv_ff && node_match) begin
         leaf_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_pt) begin
         mem_x[count_ff[AW-1:0]] <= req_pos_x;
         mem_y[count_ff[AW-1:0]] <= req_pos_y;
      end
      if (leaf_we)
         mem_leaf[leaf_wa] <= leaf_wd;
      rd_x_ff    <= mem_x[rd_addr];
      rd_y_ff    <= mem_y[rd_addr];
      rd_leaf_ff <= mem_leaf[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_mode_ff <= MODE_MEAN;
         tree_depth_ff <= DEPTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPLIT_MODE: split_mode_ff <= csr_wdata[0];
            CSR_TREE_DEPTH: tree_depth_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   kdp_div #(.SUM_W(SW), .CNT_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (cnt_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         box_lx_ff    <= CMAX;
         box_ly_ff    <= CMAX;
         box_hx_ff    <= CMIN;
         box_hy_ff    <= CMIN;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (out_xfer && !emit_now)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (in_xfer) begin
                  count_ff  <= count_new;
                  box_lx_ff <= nlx;
                  box_ly_ff <= nly;
                  box_hx_ff <= nhx;
                  box_hy_ff <= nhy;
                  if (req_final_point) begin
                     cur_lx_ff <= nlx;
                     cur_ly_ff <= nly;
                     cur_hx_ff <= nhx;
                     cur_hy_ff <= nhy;
                     depth_ff  <= depth_clamp;
                     lvl_ff    <= '0;
                     path_ff   <= '0;
                     idx_ff    <= '0;
                     lf_ff     <= '0;
                     em_cnt_ff <= '0;
                     // an empty set leaves the box at its reset value
                     if (count_new != '0) begin
                        if (depth_clamp == LVW'(1)) begin
                           state_ff <= ST_EMIT_RD;
                        end else begin
                           state_ff <= ST_NODE;
                        end
                     end
                  end
               end
            end
            ST_NODE: begin
               on_x_ff <= on_x_now;
               idx_ff  <= '0;
               pv_ff   <= 1'b0;
               acc_ff  <= '0;
               cnt_ff  <= '0;
               if (split_mode_ff == MODE_MIDDLE) begin
                  split_ff <= mid[CB-1:0];
                  state_ff <= ST_ASGN;
               end else begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               pv_ff   <= issue;
               pidx_ff <= idx_ff[AW-1:0];
               if (issue)
                  idx_ff <= idx_ff + CW'(1);
               if (pv_ff && node_match) begin
                  acc_ff <= acc_ff + SW'(sel_coord);
                  cnt_ff <= cnt_ff + CW'(1);
               end
               if (sweep_end) begin
                  idx_ff <= '0;
                  if (cnt_ff == '0) begin
                     split_ff <= '0;
                     state_ff <= ST_ASGN;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  split_ff <= div_q[CB-1:0];
                  state_ff <= ST_ASGN;
               end
            end
            ST_ASGN: begin
               pv_ff   <= issue;
               pidx_ff <= idx_ff[AW-1:0];
               if (issue)
                  idx_ff <= idx_ff + CW'(1);
               if (sweep_end)
                  state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               idx_ff <= '0;
               if (lvl_ff + LVW'(2) < depth_ff) begin
                  // descend left, keep the right box for later
                  lvl_ff    <= lvl_ff + LVW'(1);
                  cur_hx_ff <= lft_hx;
                  cur_hy_ff <= lft_hy;
                  stk_lx[SKW'(lvl_ff + LVW'(1))] <= rgt_lx;
                  stk_ly[SKW'(lvl_ff + LVW'(1))] <= rgt_ly;
                  stk_hx[SKW'(lvl_ff + LVW'(1))] <= cur_hx_ff;
                  stk_hy[SKW'(lvl_ff + LVW'(1))] <= cur_hy_ff;
                  state_ff  <= ST_NODE;
               end else if (found) begin
                  lvl_ff    <= jsel;
                  path_ff   <= (path_ff & ~(ALL1 >> (jsel - LVW'(1))))
                               | (MSB1 >> (jsel - LVW'(1)));
                  cur_lx_ff <= stk_lx[SKW'(jsel)];
                  cur_ly_ff <= stk_ly[SKW'(jsel)];
                  cur_hx_ff <= stk_hx[SKW'(jsel)];
                  cur_hy_ff <= stk_hy[SKW'(jsel)];
                  state_ff  <= ST_NODE;
               end else begin
                  state_ff <= ST_EMIT_RD;
               end
            end
            ST_EMIT_RD: begin
               if (idx_ff == count_ff) begin
                  idx_ff <= '0;
                  lf_ff  <= lf_ff + lf_step;
               end else begin
                  state_ff <= ST_EMIT_CHK;
               end
            end
            ST_EMIT_CHK: begin
               if (!emit_match) begin
                  idx_ff   <= idx_ff + CW'(1);
                  state_ff <= ST_EMIT_RD;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= rd_x_ff;
                  out_y_ff     <= rd_y_ff;
                  out_leaf_ff  <= leaf_wide[LEAF_W-1:0];
                  out_end_ff   <= (em_cnt_ff == count_ff - CW'(1));
                  em_cnt_ff    <= em_cnt_ff + CW'(1);
                  idx_ff       <= idx_ff + CW'(1);
                  if (em_cnt_ff == count_ff - CW'(1)) begin
                     // set done, back to empty
                     count_ff  <= '0;
                     box_lx_ff <= CMAX;
                     box_ly_ff <= CMAX;
                     box_hx_ff <= CMIN;
                     box_hy_ff <= CMIN;
                     state_ff  <= ST_IDLE;
                  end else begin
                     state_ff <= ST_EMIT_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = out_x_ff;
   assign rsp_out_y      = out_y_ff;
   assign rsp_leaf_id    = out_leaf_ff;
   assign rsp_end_of_set = out_end_ff;

   assign emitting    = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_CHK);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_x, rsp_out_y, rsp_leaf_id, rsp_end_of_set};

   `KDP_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(MAX_POINTS), "point count past store size")
   `KDP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled rsp changed")
   `KDP_ASSERT_IMPL(a_div_done_state, div_stat.done, state_ff == ST_DIV, "divider done outside divide")
   `KDP_ASSERT_IMPL(a_emit_count, emitting, em_cnt_ff < count_ff, "emitted more points than stored")

endmodule

// ===== sim/tb.sv =====
module tb;
   import kdp_pkg::*;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int STORE_DEPTH  = 64;
   localparam int LEVELS_MAX   = 6;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [LEAF_W-1:0]  leaf;
      logic               last;
   } leaf_point_type;

   class partition_scoreboard_type;
      longint px[STORE_DEPTH];
      longint py[STORE_DEPTH];
      int     path[STORE_DEPTH];
      int     count;
      longint min_x, min_y, max_x, max_y;
      logic   mode;
      int     depth_reg;
      leaf_point_type emitted_q[$];
      int     errors;

      function new();
         mode = MODE_MEAN;
         depth_reg = DEPTH_RESET;
         errors = 0;
         clear_set();
      endfunction

      function void clear_set();
         count = 0;
         min_x = 32767; min_y = 32767;
         max_x = -32768; max_y = -32768;
      endfunction

      function longint floor_div(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q -= 1;
         return q;
      endfunction

      function void split_points(int depth);
         longint lx[32], ly[32], hx[32], hy[32], sp[32];
         bit onx[32];
         longint a, b, c, d, sum, cnt, v;
         int nodes, p;
         lx[0] = min_x; ly[0] = min_y; hx[0] = max_x; hy[0] = max_y;
         for (int i = 0; i < count; i++) path[i] = 0;
         for (int lvl = 0; lvl + 1 < depth; lvl++) begin
            nodes = 1 << lvl;
            for (int n = 0; n < nodes; n++) begin
               onx[n] = (hx[n] - lx[n]) > (hy[n] - ly[n]);
               if (mode == MODE_MEAN) begin
                  sum = 0; cnt = 0;
                  for (int i = 0; i < count; i++)
                     if (path[i] == n) begin
                        sum += onx[n] ? px[i] : py[i];
                        cnt++;
                     end
                  sp[n] = cnt != 0 ? floor_div(sum, cnt) : 0;
               end else begin
                  sp[n] = onx[n] ? floor_div(lx[n] + hx[n], 2) : floor_div(ly[n] + hy[n], 2);
               end
            end
            // high nodes first so parent boxes are read before being overwritten
            for (int n = nodes - 1; n >= 0; n--) begin
               a = lx[n]; b = ly[n]; c = hx[n]; d = hy[n];
               lx[2*n] = a; ly[2*n] = b; hx[2*n] = c; hy[2*n] = d;
               lx[2*n+1] = a; ly[2*n+1] = b; hx[2*n+1] = c; hy[2*n+1] = d;
               if (onx[n]) begin
                  hx[2*n] = sp[n]; lx[2*n+1] = sp[n];
               end else begin
                  hy[2*n] = sp[n]; ly[2*n+1] = sp[n];
               end
            end
            for (int i = 0; i < count; i++) begin
               p = path[i] & (nodes - 1);
               v = onx[p] ? px[i] : py[i];
               path[i] = 2 * p + (v < sp[p] ? 0 : 1);
            end
         end
      endfunction

      function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                               logic dropped, logic final_point);
         int depth, first;
         leaf_point_type e;
         if (!dropped && count < STORE_DEPTH) begin
            px[count] = x; py[count] = y; count++;
            if (x < min_x) min_x = x;
            if (y < min_y) min_y = y;
            if (x > max_x) max_x = x;
            if (y > max_y) max_y = y;
         end
         if (!final_point) return;
         depth = depth_reg < 1 ? 1 : (depth_reg > LEVELS_MAX ? LEVELS_MAX : depth_reg);
         split_points(depth);
         first = emitted_q.size();
         for (int lf = 0; lf < (1 << (depth - 1)); lf++)
            for (int i = 0; i < count; i++)
               if (path[i] == lf) begin
                  e.x = 16'(px[i]); e.y = 16'(py[i]);
                  e.leaf = LEAF_W'(lf); e.last = 1'b0;
                  emitted_q = {emitted_q, e};
               end
         if (emitted_q.size() > first) emitted_q[emitted_q.size() - 1].last = 1'b1;
         clear_set();
      endfunction

      function void check_point(logic signed [15:0] x, logic signed [15:0] y,
                                logic [LEAF_W-1:0] leaf, logic last);
         leaf_point_type e;
         if (emitted_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected point x=%0d y=%0d leaf=%0d end=%0d", x, y, leaf, last);
            return;
         end
         e = emitted_q.pop_front();
         if (e.x !== x || e.y !== y || e.leaf !== leaf || e.last !== last) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected x=%0d y=%0d leaf=%0d end=%0d, ",
                         "got x=%0d y=%0d leaf=%0d end=%0d"},
                        e.x, e.y, e.leaf, e.last, x, y, leaf, last);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, req_dropped, req_final_point;
   logic signed [15:0] req_pos_x, req_pos_y;
   logic rsp_valid, rsp_ready, rsp_end_of_set;
   logic signed [15:0] rsp_out_x, rsp_out_y;
   logic [LEAF_W-1:0] rsp_leaf_id;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   partition_scoreboard_type sb;
   int send_idle_pct, recv_idle_pct;
   int cycles = 0;

   kd_tree_point_partition dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_point(rsp_out_x, rsp_out_y, rsp_leaf_id, rsp_end_of_set);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic dropped, logic final_point);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_dropped <= dropped;
      req_final_point <= final_point;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_point(x, y, dropped, final_point);
   endtask

   task automatic settle();
      req_valid <= 0;
      while (sb.emitted_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_cfg(logic mode, logic [CSR_DATA_W-1:0] depth);
      settle();
      csr_we <= 1; csr_index <= CSR_SPLIT_MODE; csr_wdata <= {2'b0, mode};
      @(posedge clock);
      csr_index <= CSR_TREE_DEPTH; csr_wdata <= depth;
      @(posedge clock);
      csr_we <= 0;
      sb.mode = mode;
      sb.depth_reg = depth;
   endtask

   function automatic logic signed [15:0] rand_coord(int spread);
      case (spread)
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(40))) - 16'sd20;
         default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
   endfunction

   // a set of random points, most kept, final flag on the last one
   task automatic send_set(int n);
      int spread;
      spread = $urandom_range(9) < 6 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
      for (int i = 0; i < n; i++)
         send_point(rand_coord(spread), rand_coord(spread),
                    $urandom_range(9) == 0, i == n - 1);
   endtask

   task automatic random_phase(int sets);
      for (int s = 0; s < sets; s++) begin
         if ($urandom_range(3) == 0)
            write_cfg(1'($urandom_range(1)), 3'($urandom_range(7)));
         if ($urandom_range(19) == 0)
            send_point(16'($urandom), 16'($urandom), 1'b1, 1'b1);
         else
            send_set($urandom_range(1, 12));
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset <= 1;
      req_valid <= 0; req_pos_x <= 0; req_pos_y <= 0;
      req_dropped <= 0; req_final_point <= 0;
      rsp_ready <= 0;
      csr_we <= 0; csr_index <= CSR_SPLIT_MODE; csr_wdata <= 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, empty set, dropped final, depth limits
      send_point(16'sh8000, 16'sh8000, 1'b0, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
      send_point(16'sd0, -16'sd1, 1'b0, 1'b0);
      send_point(-16'sd1, 16'sd0, 1'b0, 1'b1);
      send_point(16'sd5, 16'sd5, 1'b1, 1'b1);
      write_cfg(MODE_MIDDLE, 3'd1);
      send_point(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
      send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
      write_cfg(MODE_MEAN, 3'd0);
      send_point(16'sd3, 16'sd4, 1'b0, 1'b0);
      send_point(16'sd7, 16'sd8, 1'b0, 1'b0);
      send_point(16'sd1, 16'sd1, 1'b1, 1'b1);
      write_cfg(MODE_MIDDLE, 3'd7);
      send_point(16'sh8000, 16'sd0, 1'b0, 1'b0);
      send_point(16'sh7fff, 16'sd1, 1'b0, 1'b0);
      send_point(16'sd0, 16'sh7fff, 1'b0, 1'b0);
      send_point(-16'sd5, 16'sh8000, 1'b0, 1'b1);
      write_cfg(MODE_MEAN, 3'd6);
      send_point(16'sd10, 16'sd10, 1'b0, 1'b0);
      send_point(16'sd10, 16'sd10, 1'b0, 1'b0);
      send_point(-16'sd10, 16'sd20, 1'b0, 1'b1);

      send_idle_pct = 26; recv_idle_pct = 59;
      random_phase(3);
      // store overflow: more points than the store holds
      write_cfg(1'($urandom_range(1)), 3'd6);
      for (int i = 0; i < 68; i++)
         send_point(16'($urandom), 16'($urandom), 1'b0, i == 67);
      send_idle_pct = 59; recv_idle_pct = 26;
      random_phase(2);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(2);

      settle();
      if (sb.errors == 0 && sb.emitted_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
